FILE: hdl/hws_pkg.sv
// shared types and constants of the hashed wavelength sampler
package hws_pkg;

   localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

   localparam int WL_W   = 24;
   localparam int U_W    = 53;
   localparam int QUO_W  = 26;
   localparam int DEN_W  = 78;
   localparam int DVSR_W = 79;
   localparam int REM_W  = 104;

   localparam logic [1:0] REG_RESOLVE_ENABLE = 2'd0;
   localparam logic [1:0] REG_HASH_SEED      = 2'd1;
   localparam logic [1:0] REG_MIN_WAVELENGTH = 2'd2;
   localparam logic [1:0] REG_MAX_WAVELENGTH = 2'd3;

   typedef struct packed {
      logic [23:0] raw_wavelength;
      logic [29:0] event_number;
      logic [15:0] array_number;
      logic [15:0] telescope_number;
      logic [30:0] bunch_index;
   } req_type;

   typedef struct packed {
      logic [23:0] wavelength;
      logic        was_resolved;
      logic        is_emitter;
   } rsp_type;

   typedef struct packed {
      logic [23:0] raw;
      logic        emitter;
      logic        resolve;
   } tag_type;

   typedef struct packed {
      req_type     item;
      tag_type     tag;
      logic [63:0] seed;
   } fold_type;

   typedef struct packed {
      tag_type           tag;
      logic [REM_W-1:0]  rem;
      logic [DVSR_W-1:0] dvsr;
      logic [QUO_W-1:0]  quo;
      logic              den_zero;
   } div_type;

endpackage

FILE: hdl/hws_fold_cell.sv
// one hash-combine step of the seed chain
module hws_fold_cell #(
   parameter int STEP = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_vld,
   input  hws_pkg::fold_type in_data,
   output logic              in_rdy,
   output logic              out_vld,
   output hws_pkg::fold_type out_data,
   input  logic              out_rdy
);
   import hws_pkg::*;

   logic [63:0] v;
   fold_type    data_in;
   fold_type    data_ff;
   logic        vld_ff;

   always_comb begin
      unique case (STEP)
         0: v = 64'(in_data.item.event_number) + 64'd1000003;
         1: v = 64'(in_data.item.array_number) + 64'd100003;
         2: v = 64'(in_data.item.telescope_number) + 64'd10007;
         3: v = 64'(in_data.item.bunch_index) + 64'd1;
         default: v = 64'd1;
      endcase
      data_in = in_data;
      data_in.seed = in_data.seed ^
         (v + GOLDEN + (in_data.seed << 6) + (in_data.seed >> 2));
   end

   assign in_rdy = ~vld_ff | out_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_rdy) begin
         vld_ff <= in_vld;
      end
      if (in_rdy) begin
         data_ff <= data_in;
      end
   end

   assign out_vld  = vld_ff;
   assign out_data = data_ff;
endmodule

FILE: hdl/hws_div_cell.sv
// one restoring division step, one quotient bit
module hws_div_cell #(
   parameter int BIT = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_vld,
   input  hws_pkg::div_type in_data,
   output logic             in_rdy,
   output logic             out_vld,
   output hws_pkg::div_type out_data,
   input  logic             out_rdy
);
   import hws_pkg::*;

   logic [REM_W-1:0] trial;
   div_type          data_in;
   div_type          data_ff;
   logic             vld_ff;

   always_comb begin
      trial   = REM_W'(in_data.dvsr) << BIT;
      data_in = in_data;
      if (in_data.rem >= trial) begin
         data_in.rem      = in_data.rem - trial;
         data_in.quo[BIT] = 1'b1;
      end
   end

   assign in_rdy = ~vld_ff | out_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_rdy) begin
         vld_ff <= in_vld;
      end
      if (in_rdy) begin
         data_ff <= data_in;
      end
   end

   assign out_vld  = vld_ff;
   assign out_data = data_ff;
endmodule

FILE: hdl/hashed_wavelength_sampler.sv
// top level of the hashed wavelength sampler
// Photon bunch wavelength resolver, one request per cycle sustained while
// rsp_ready does not hold the output. A request runs through a row of
// cells: five hash-combine cells fold the seed with the bunch ids, four
// stages do the splitmix64 finaliser and the denominator product
// (multiplies split into 32-bit partials), then 26 division cells each
// settle one quotient bit of lo*hi/(hi-u*(hi-lo)), and an output register.
// Every stage has its own valid bit, so gaps close up and new requests
// enter while a result waits on rsp_ready. Emitter rows and pass-through
// values ride the same pipeline, keeping order.
// Registers are read live, so write them only while the block is empty.
module hashed_wavelength_sampler #(
   parameter int FRAC_BITS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hws_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hws_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [7:0]       csr_index,
   input  logic [63:0]      csr_wdata
);
   import hws_pkg::*;

   // emitter threshold, 9000 nm in fixed point
   localparam logic [47:0] EMIT_LIMIT = 48'(9000) << FRAC_BITS;

   // configuration registers
   logic        enable_ff;
   logic [63:0] seed_ff;
   logic [23:0] lo_ff;
   logic [23:0] hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         seed_ff   <= 64'd246813579;
         lo_ff     <= 24'd66560;
         hi_ff     <= 24'd256000;
      end else if (csr_we && csr_index[7:2] == 6'd0) begin
         unique case (csr_index[1:0])
            REG_RESOLVE_ENABLE: enable_ff <= csr_wdata[0];
            REG_HASH_SEED:      seed_ff   <= csr_wdata;
            REG_MIN_WAVELENGTH: lo_ff     <= csr_wdata[23:0];
            REG_MAX_WAVELENGTH: hi_ff     <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   // hash-combine chain
   fold_type fold_data [0:5];
   logic     fold_vld  [0:5];
   logic     fold_rdy  [0:5];

   always_comb begin
      fold_data[0].item        = req_data;
      fold_data[0].seed        = seed_ff;
      fold_data[0].tag.raw     = req_data.raw_wavelength;
      fold_data[0].tag.emitter = 48'(req_data.raw_wavelength) >= EMIT_LIMIT;
      fold_data[0].tag.resolve = ~fold_data[0].tag.emitter && enable_ff &&
                                 req_data.raw_wavelength == 24'd0;
   end
   assign fold_vld[0] = req_valid;
   assign req_ready   = fold_rdy[0];

   for (genvar i = 0; i < 5; i++) begin : g_fold
      hws_fold_cell #(.STEP(i)) u_fold (
         .clock    (clock),
         .reset    (reset),
         .in_vld   (fold_vld[i]),
         .in_data  (fold_data[i]),
         .in_rdy   (fold_rdy[i]),
         .out_vld  (fold_vld[i+1]),
         .out_data (fold_data[i+1]),
         .out_rdy  (fold_rdy[i+1])
      );
   end

   // finaliser, first multiply: partial products with the first constant
   logic        m1_rdy;
   logic        m1_vld_ff;
   tag_type     m1_tag_ff;
   logic [63:0] m1_pp0_ff;
   logic [31:0] m1_pp1_ff;
   logic [31:0] m1_pp2_ff;
   logic [63:0] m1_z;
   logic [63:0] m1_x;

   // second multiply
   logic        m2_rdy;
   logic        m2_vld_ff;
   tag_type     m2_tag_ff;
   logic [63:0] m2_pp0_ff;
   logic [31:0] m2_pp1_ff;
   logic [31:0] m2_pp2_ff;
   logic [47:0] m2_lohi_ff;
   logic [63:0] m2_y;
   logic [63:0] m2_x;

   // u and the u*(hi-lo) partials
   logic        m3_rdy;
   logic        m3_vld_ff;
   tag_type     m3_tag_ff;
   logic [47:0] m3_lohi_ff;
   logic        m3_neg_ff;
   logic [55:0] m3_pl_ff;
   logic [44:0] m3_ph_ff;
   logic [63:0] m3_y;
   logic [63:0] m3_w;
   logic [52:0] m3_u;
   logic [23:0] m3_diff;
   logic        m3_neg;

   // division setup
   logic        m4_rdy;
   logic        m4_vld_ff;
   div_type     m4_data_ff;
   div_type     m4_data_in;
   logic [76:0] m4_prod;
   logic [DEN_W-1:0] m4_den;

   // division chain links
   div_type div_data [0:QUO_W];
   logic    div_vld  [0:QUO_W];
   logic    div_rdy  [0:QUO_W];

   assign fold_rdy[5] = m1_rdy;
   assign m1_z = fold_data[5].seed + GOLDEN;
   assign m1_x = m1_z ^ (m1_z >> 30);
   assign m1_rdy = ~m1_vld_ff | m2_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
      end else if (m1_rdy) begin
         m1_vld_ff <= fold_vld[5];
      end
      if (m1_rdy) begin
         m1_tag_ff <= fold_data[5].tag;
         m1_pp0_ff <= 64'(m1_x[31:0]) * 64'(MIX_C1[31:0]);
         m1_pp1_ff <= 32'(m1_x[31:0] * MIX_C1[63:32]);
         m1_pp2_ff <= 32'(m1_x[63:32] * MIX_C1[31:0]);
      end
   end

   assign m2_y = m1_pp0_ff + {m1_pp1_ff + m1_pp2_ff, 32'd0};
   assign m2_x = m2_y ^ (m2_y >> 27);
   assign m2_rdy = ~m2_vld_ff | m3_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_vld_ff <= 1'b0;
      end else if (m2_rdy) begin
         m2_vld_ff <= m1_vld_ff;
      end
      if (m2_rdy) begin
         m2_tag_ff  <= m1_tag_ff;
         m2_pp0_ff  <= 64'(m2_x[31:0]) * 64'(MIX_C2[31:0]);
         m2_pp1_ff  <= 32'(m2_x[31:0] * MIX_C2[63:32]);
         m2_pp2_ff  <= 32'(m2_x[63:32] * MIX_C2[31:0]);
         m2_lohi_ff <= 48'(lo_ff) * 48'(hi_ff);
      end
   end

   always_comb begin
      m3_y = m2_pp0_ff + {m2_pp1_ff + m2_pp2_ff, 32'd0};
      m3_w = m3_y ^ (m3_y >> 31);
      m3_u = m3_w[63:11];
      if (m3_u == 53'd0) begin
         m3_u = 53'd1;
      end
      m3_neg  = hi_ff < lo_ff;
      m3_diff = m3_neg ? lo_ff - hi_ff : hi_ff - lo_ff;
   end
   assign m3_rdy = ~m3_vld_ff | m4_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         m3_vld_ff <= 1'b0;
      end else if (m3_rdy) begin
         m3_vld_ff <= m2_vld_ff;
      end
      if (m3_rdy) begin
         m3_tag_ff  <= m2_tag_ff;
         m3_lohi_ff <= m2_lohi_ff;
         m3_neg_ff  <= m3_neg;
         m3_pl_ff   <= 56'(m3_u[31:0]) * 56'(m3_diff);
         m3_ph_ff   <= 45'(m3_u[52:32]) * 45'(m3_diff);
      end
   end

   // den = hi*2^53 -/+ u*|hi-lo|; numerator carries the rounding half
   always_comb begin
      m4_prod = 77'(m3_pl_ff) + {m3_ph_ff, 32'd0};
      if (m3_neg_ff) begin
         m4_den = {1'b0, hi_ff, 53'd0} + DEN_W'(m4_prod);
      end else begin
         m4_den = {1'b0, hi_ff, 53'd0} - DEN_W'(m4_prod);
      end
      m4_data_in.tag      = m3_tag_ff;
      m4_data_in.rem      = (REM_W'(m3_lohi_ff) << 54) + REM_W'(m4_den);
      m4_data_in.dvsr     = {m4_den, 1'b0};
      m4_data_in.quo      = '0;
      m4_data_in.den_zero = m4_den == '0;
   end
   assign m4_rdy = ~m4_vld_ff | div_rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         m4_vld_ff <= 1'b0;
      end else if (m4_rdy) begin
         m4_vld_ff <= m3_vld_ff;
      end
      if (m4_rdy) begin
         m4_data_ff <= m4_data_in;
      end
   end

   // division chain, most significant quotient bit first
   assign div_data[0] = m4_data_ff;
   assign div_vld[0]  = m4_vld_ff;

   for (genvar i = 0; i < QUO_W; i++) begin : g_div
      hws_div_cell #(.BIT(QUO_W - 1 - i)) u_div (
         .clock    (clock),
         .reset    (reset),
         .in_vld   (div_vld[i]),
         .in_data  (div_data[i]),
         .in_rdy   (div_rdy[i]),
         .out_vld  (div_vld[i+1]),
         .out_data (div_data[i+1]),
         .out_rdy  (div_rdy[i+1])
      );
   end

   // output register with saturation and selection
   logic        out_rdy;
   logic        out_vld_ff;
   rsp_type     out_data_ff;
   rsp_type     out_data_in;
   logic [23:0] drawn;
   div_type     last;

   always_comb begin
      last = div_data[QUO_W];
      if (last.den_zero) begin
         drawn = 24'd0;
      end else if (last.quo > QUO_W'(24'hFFFFFF)) begin
         drawn = 24'hFFFFFF;
      end else begin
         drawn = last.quo[23:0];
      end
      out_data_in.wavelength   = last.tag.resolve ? drawn : last.tag.raw;
      out_data_in.was_resolved = last.tag.resolve;
      out_data_in.is_emitter   = last.tag.emitter;
   end

   assign out_rdy        = ~out_vld_ff | rsp_ready;
   assign div_rdy[QUO_W] = out_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_rdy) begin
         out_vld_ff <= div_vld[QUO_W];
      end
      if (out_rdy) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;
endmodule

FILE: sim/hws_checker.sv
// request/response checker with a wavelength predictor for the hashed wavelength sampler
`timescale 1ns / 100ps

module hws_checker #(
   parameter int FRAC_BITS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  hws_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  hws_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [7:0]       csr_index,
   input  logic [63:0]      csr_wdata,
   output int               fail_count,
   output int               pending
);
   import hws_pkg::*;

   localparam logic [23:0] EMITTER_LIMIT = 24'(9000 << FRAC_BITS);
   localparam logic [52:0] U_TOP = {53{1'b1}};

   logic        cfg_resolve;
   logic [63:0] cfg_seed;
   logic [23:0] cfg_min;
   logic [23:0] cfg_max;
   rsp_type     expected_rsp[$];

   function automatic logic [63:0] fold_id(logic [63:0] s, logic [63:0] v);
      return s ^ (v + GOLDEN + (s << 6) + (s >> 2));
   endfunction

   function automatic logic [63:0] splitmix_finish(logic [63:0] z);
      z = z + GOLDEN;
      z = (z ^ (z >> 30)) * MIX_C1;
      z = (z ^ (z >> 27)) * MIX_C2;
      return z ^ (z >> 31);
   endfunction

   // exact lo*hi/(hi-u*(hi-lo)) with u = ud/2^53, rounded half up
   function automatic logic [23:0] spectrum_draw(logic [52:0] ud, logic [23:0] lo,
                                                 logic [23:0] hi);
      logic [127:0] den;
      logic [127:0] num;
      logic [127:0] t;
      logic [25:0]  q;
      if (hi >= lo)
         den = (128'(hi) << 53) - 128'(ud) * 128'(hi - lo);
      else
         den = (128'(hi) << 53) + 128'(ud) * 128'(lo - hi);
      if (den == 128'd0) return 24'd0;
      num = ((128'(lo) * 128'(hi)) << 54) + den;
      den = den << 1;
      q = '0;
      for (int b = 25; b >= 0; b--) begin
         t = den << b;
         if (num >= t) begin
            num = num - t;
            q[b] = 1'b1;
         end
      end
      return (q > 26'hFFFFFF) ? 24'hFFFFFF : q[23:0];
   endfunction

   function automatic rsp_type predict_wavelength(req_type r);
      rsp_type     o;
      logic [63:0] s;
      logic [63:0] ud;
      o.wavelength   = r.raw_wavelength;
      o.was_resolved = 1'b0;
      o.is_emitter   = 1'b0;
      if (r.raw_wavelength >= EMITTER_LIMIT) begin
         o.is_emitter = 1'b1;
         return o;
      end
      if (r.raw_wavelength != 24'd0 || !cfg_resolve) return o;
      s = cfg_seed;
      s = fold_id(s, 64'(r.event_number) + 64'd1000003);
      s = fold_id(s, 64'(r.array_number) + 64'd100003);
      s = fold_id(s, 64'(r.telescope_number) + 64'd10007);
      s = fold_id(s, 64'(r.bunch_index) + 64'd1);
      s = fold_id(s, 64'd1);
      ud = splitmix_finish(s) >> 11;
      if (ud < 64'd1) ud = 64'd1;
      if (ud > 64'(U_TOP)) ud = 64'(U_TOP);
      o.wavelength   = spectrum_draw(ud[52:0], cfg_min, cfg_max);
      o.was_resolved = 1'b1;
      return o;
   endfunction

   initial begin
      fail_count = 0;
   end

   assign pending = expected_rsp.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cfg_resolve <= 1'b0;
         cfg_seed    <= 64'd246813579;
         cfg_min     <= 24'd66560;
         cfg_max     <= 24'd256000;
      end else begin
         if (csr_we) begin
            case (csr_index)
               8'(REG_RESOLVE_ENABLE): cfg_resolve <= csr_wdata[0];
               8'(REG_HASH_SEED):      cfg_seed    <= csr_wdata;
               8'(REG_MIN_WAVELENGTH): cfg_min     <= csr_wdata[23:0];
               8'(REG_MAX_WAVELENGTH): cfg_max     <= csr_wdata[23:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) expected_rsp.push_back(predict_wavelength(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $error("response with nothing expected: %h", rsp_data);
               fail_count++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.wavelength !== want.wavelength) begin
                  $error("wavelength: expected %0d, got %0d", want.wavelength,
                         rsp_data.wavelength);
                  fail_count++;
               end
               if (rsp_data.was_resolved !== want.was_resolved) begin
                  $error("was_resolved: expected %0b, got %0b", want.was_resolved,
                         rsp_data.was_resolved);
                  fail_count++;
               end
               if (rsp_data.is_emitter !== want.is_emitter) begin
                  $error("is_emitter: expected %0b, got %0b", want.is_emitter,
                         rsp_data.is_emitter);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

FILE: sim/hashed_wavelength_sampler_tb.sv
// testbench top: stimulus, register phases and verdict for the hashed wavelength sampler
`timescale 1ns / 100ps

module hashed_wavelength_sampler_tb;
   import hws_pkg::*;

   localparam int          CYCLE_LIMIT   = 400000;
   localparam int          DRAIN_CYCLES  = 60;   // more than the pipeline depth
   localparam logic [23:0] EMITTER_LIMIT = 24'(9000 << 8);

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [7:0]  csr_index;
   logic [63:0] csr_wdata;
   int          fail_count;
   int          pending;
   int          cycle_count;
   logic        req_taken;
   bit          hold_wanted;

   hashed_wavelength_sampler dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   hws_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // request handshake seen at the edge, used by the sender at the next falling edge
   always @(posedge clock) begin
      req_taken <= req_valid && req_ready;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("hashed_wavelength_sampler_tb NOT OK");
         $finish;
      end
   end

   // response side: a randomly chosen stall pattern per phase, plus a long hold-off on request
   initial begin
      int mode;
      int hold_left;
      int phase_left;
      rsp_ready = 1'b0;
      hold_left = 0;
      phase_left = 0;
      mode = 0;
      forever begin
         @(negedge clock);
         if (hold_wanted) begin
            hold_wanted = 1'b0;
            hold_left = 500;
         end
         if (phase_left == 0) begin
            mode = $urandom_range(0, 3);
            phase_left = 64;
         end
         phase_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) == 1);
               2: rsp_ready <= ($urandom_range(0, 9) != 0);
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // register write, done at the falling edge while nothing is in flight
   task automatic write_reg(logic [7:0] idx, logic [63:0] val);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   task automatic set_regs(logic en, logic [63:0] seed, logic [23:0] lo, logic [23:0] hi);
      write_reg(8'(REG_RESOLVE_ENABLE), 64'(en));
      write_reg(8'(REG_HASH_SEED), seed);
      write_reg(8'(REG_MIN_WAVELENGTH), 64'(lo));
      write_reg(8'(REG_MAX_WAVELENGTH), 64'(hi));
   endtask

   // wait until every expected response is back, then let the pipe settle
   task automatic drain();
      if (req_valid) req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // offer one request and hold it until taken; returns at the falling edge after
   task automatic send_request(req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      @(negedge clock);
      while (!req_taken) @(negedge clock);
   endtask

   function automatic req_type bunch(logic [23:0] raw, logic [29:0] ev, logic [15:0] arr,
                                     logic [15:0] tel, logic [30:0] idx);
      req_type r;
      r.raw_wavelength   = raw;
      r.event_number     = ev;
      r.array_number     = arr;
      r.telescope_number = tel;
      r.bunch_index      = idx;
      return r;
   endfunction

   function automatic req_type random_bunch();
      req_type r;
      int      pick;
      r = bunch(24'd0, 30'($urandom), 16'($urandom), 16'($urandom), 31'($urandom));
      pick = $urandom_range(0, 9);
      // half of them missing wavelengths so the draw path gets the largest share of the traffic
      if (pick < 5)
         r.raw_wavelength = 24'd0;
      else if (pick < 7)
         r.raw_wavelength = 24'($urandom_range(int'(EMITTER_LIMIT), 24'hFFFFFF));
      else if (pick < 8)
         r.raw_wavelength = 24'($urandom_range(1, 3));
      else
         r.raw_wavelength = 24'($urandom_range(1, int'(EMITTER_LIMIT) - 1));
      return r;
   endfunction

   // bursty sender: random bursts with random gaps, some stretches with no gaps
   task automatic send_random(int count);
      int burst;
      int gap;
      burst = 0;
      for (int n = 0; n < count; n++) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         burst--;
         send_request(random_bunch());
      end
   endtask

   function automatic logic [23:0] random_bound();
      case ($urandom_range(0, 5))
         0: return 24'd1;
         1: return 24'hFFFFFF;
         2: return 24'($urandom_range(1, 255));
         default: return 24'($urandom_range(1, 24'hFFFFFF));
      endcase
   endfunction

   initial begin
      logic [23:0] lo;
      logic [23:0] hi;
      hold_wanted = 1'b0;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      reset     = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset registers: resolving off, so a missing wavelength stays zero
      send_request(bunch(24'd0, 30'd5, 16'd1, 16'd2, 31'd3));
      send_request(bunch(24'd66560, 30'd0, 16'd0, 16'd0, 31'd0));
      drain();

      // resolving on, default spectrum; extremes of the raw value and the ids
      write_reg(8'(REG_RESOLVE_ENABLE), 64'd1);
      write_reg(8'd4, 64'd0);            // unknown index, ignored
      write_reg(8'd255, 64'hFFFF);       // unknown index, ignored
      send_request(bunch(24'd0, 30'd0, 16'd0, 16'd0, 31'd0));
      send_request(bunch(24'd0, '1, '1, '1, '1));
      send_request(bunch(24'd1, '1, '1, '1, '1));
      send_request(bunch(EMITTER_LIMIT - 24'd1, 30'd7, 16'd8, 16'd9, 31'd10));
      send_request(bunch(EMITTER_LIMIT, 30'd7, 16'd8, 16'd9, 31'd10));
      send_request(bunch(24'hFFFFFF, 30'd0, 16'd0, 16'd0, 31'd0));
      send_request(bunch(24'd0, 30'h2AAAAAAA, 16'h5555, 16'hAAAA, 31'h55555555));
      drain();

      // bounds inverted, seed all ones
      set_regs(1'b1, '1, 24'hFFFFFF, 24'd1);
      send_request(bunch(24'd0, 30'd1, 16'd2, 16'd3, 31'd4));
      send_request(bunch(24'd0, '1, 16'd0, '1, 31'd0));
      drain();
      // equal bounds at the top
      set_regs(1'b1, 64'd0, 24'hFFFFFF, 24'hFFFFFF);
      send_request(bunch(24'd0, 30'd1, 16'd2, 16'd3, 31'd4));
      drain();
      // both bounds zero: the draw gives zero
      set_regs(1'b1, 64'd0, 24'd0, 24'd0);
      send_request(bunch(24'd0, 30'd1, 16'd2, 16'd3, 31'd4));
      drain();
      // lower bound zero
      set_regs(1'b1, 64'h8000_0000_0000_0001, 24'd0, 24'hFFFFFF);
      send_request(bunch(24'd0, 30'd1, 16'd2, 16'd3, 31'd4));
      send_request(bunch(24'd0, 30'd9, 16'd9, 16'd9, 31'd9));
      // widest spectrum
      drain();
      set_regs(1'b1, 64'd246813579, 24'd1, 24'hFFFFFF);
      send_request(bunch(24'd0, 30'd1, 16'd2, 16'd3, 31'd4));
      send_request(bunch(24'd0, '1, '1, '1, '1));
      drain();

      // random phases, each under its own register setting
      for (int ph = 0; ph < 5; ph++) begin
         lo = random_bound();
         hi = random_bound();
         if (ph == 0) begin
            lo = 24'd66560;
            hi = 24'd256000;
         end else if (ph != 3 && lo >= hi) begin
            lo = 24'd1;
            hi = 24'hFFFFFF;
         end
         set_regs((ph != 4) || ($urandom_range(0, 1) == 1),
                  {32'($urandom), 32'($urandom)}, lo, hi);
         // the long hold-off starts with the stream so the pipe backs up onto the input
         if (ph == 1) hold_wanted = 1'b1;
         send_random(140);
         drain();
      end

      if (fail_count == 0) begin
         $display("hashed_wavelength_sampler_tb OK");
      end else begin
         $display("hashed_wavelength_sampler_tb NOT OK");
      end
      $finish;
   end

endmodule
